[src/spua_pkg.sv]
// constants and widths for the sensor packet unwrap block
package spua_pkg;

  localparam int BYTE_W  = 8;
  localparam int SIG_W   = 15;
  localparam int MAG_W   = 11;
  localparam int LEN_W   = 2;
  localparam int SUM_W   = 16;
  localparam int ROOT_W  = 16;
  localparam int REM_W   = 18;
  localparam int DREM_W  = 6;
  localparam int STEP_W  = 4;

  localparam logic [BYTE_W-1:0] HDR_SUMMARY = 8'hFE;
  localparam logic [LEN_W-1:0]  LEN_SIX     = 2'd0;
  localparam logic [LEN_W-1:0]  LEN_FIVE    = 2'd1;
  localparam logic [BYTE_W-1:0] ACC_MID     = 8'h80;
  localparam logic [BYTE_W-1:0] HI_LEVEL    = 8'd230;
  localparam logic [BYTE_W-1:0] LO_LEVEL    = 8'd25;
  localparam logic [BYTE_W-1:0] OFFSET_MIN  = 8'd127;
  localparam logic [6:0]        MAG_DIV     = 7'd44;
  localparam logic signed [BYTE_W-1:0] WRAP_MAX = 8'sd127;
  localparam logic signed [BYTE_W-1:0] WRAP_MIN = -8'sd128;

endpackage

[src/sensor_packet_unwrap_accel_magnitude.sv]
// sensor summary packet unwrap with serial acceleration magnitude
//
// One input word is one received packet; one output word follows for every
// input word. The input channel (in_valid/in_ready) is taken only while the
// block is idle. A summary packet (header 0xFE, six or five byte class)
// updates the held pressure level, accelerometer bytes, fall count and the
// acceleration magnitude; any other packet leaves them unchanged.
// A rejected packet goes from idle straight to the done state, which loads
// the output register. An accepted summary packet passes through a sum of
// squares on one shared multiplier, the two-bit-per-cycle square root,
// the one-bit-per-cycle divide by 44 and the load of the output register.
// The next word is taken the cycle after the output register is loaded, so
// no new packet is taken until the word for the last one is loaded.
// When the receiver stalls, the finished word waits in the output register;
// a later result waits in its done state until that register is free.
// unwrap_enable is written through cfg_write/cfg_data; the user must write
// it only while idle, which the block itself does not enforce.
// Reset (rst, synchronous) clears all held values, the wrap count, the
// offset and the initialised flag, and disables unwrapping.
module sensor_packet_unwrap_accel_magnitude (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic                        cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [spua_pkg::BYTE_W-1:0] header_byte,
  input  logic [spua_pkg::BYTE_W-1:0] in_acc_x,
  input  logic [spua_pkg::BYTE_W-1:0] in_acc_y,
  input  logic [spua_pkg::BYTE_W-1:0] in_acc_z,
  input  logic [spua_pkg::BYTE_W-1:0] pressure_byte,
  input  logic [spua_pkg::BYTE_W-1:0] fall_byte,
  input  logic [spua_pkg::LEN_W-1:0]  length_class,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [spua_pkg::SIG_W-1:0]  unwrapped_signal,
  output logic [spua_pkg::BYTE_W-1:0] out_acc_x,
  output logic [spua_pkg::BYTE_W-1:0] out_acc_y,
  output logic [spua_pkg::BYTE_W-1:0] out_acc_z,
  output logic [spua_pkg::MAG_W-1:0]  accel_magnitude,
  output logic [spua_pkg::BYTE_W-1:0] fall_total,
  output logic                        packet_valid
);
  import spua_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQUARE,
    S_ROOT,
    S_DIVIDE,
    S_DONE
  } state_t;

  state_t state;

  // held state
  logic                     unwrap_enable;
  logic [BYTE_W-1:0]        raw_level;
  logic [BYTE_W-1:0]        previous_level;
  logic signed [BYTE_W-1:0] wrap_count;
  logic [BYTE_W-1:0]        zero_offset;
  logic                     initialised;
  logic [BYTE_W-1:0]        held_accel [3];
  logic [MAG_W-1:0]         held_magnitude;
  logic [BYTE_W-1:0]        held_falls;

  // per word work registers
  logic              pend_valid;
  logic [SIG_W-1:0]  pend_signal;
  logic [1:0]        acc_idx;
  logic [STEP_W-1:0] step;
  logic [SUM_W-1:0]  sum_sq;
  logic [SUM_W-1:0]  src_shift;
  logic [REM_W-1:0]  root_rem;
  logic [ROOT_W-1:0] root;
  logic [DREM_W-1:0] div_rem;

  logic                     accept;
  logic                     pkt_ok;
  logic [BYTE_W-1:0]        raw_next;
  logic signed [BYTE_W-1:0] wrap_count_next;
  logic signed [16:0]       sig_full;
  logic [SIG_W-1:0]         sig_clamped;
  logic [BYTE_W-1:0]        acc_sel;
  logic [BYTE_W-1:0]        dev_abs;
  logic [SUM_W-1:0]         dev_sq;
  logic [REM_W+1:0]         root_shift;
  logic [REM_W+1:0]         root_trial;
  logic                     root_take;
  logic [DREM_W:0]          div_shift;
  logic                     div_take;
  logic                     out_free;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // packet check and rollover tracking
  always_comb begin
    pkt_ok = (header_byte == HDR_SUMMARY) &&
             ((length_class == LEN_SIX) || (length_class == LEN_FIVE));
    raw_next = pkt_ok ? pressure_byte : raw_level;
    wrap_count_next = wrap_count;
    if (initialised && unwrap_enable) begin
      if ((raw_level >= HI_LEVEL) && (raw_next <= LO_LEVEL)) begin
        if (wrap_count < WRAP_MAX) wrap_count_next = wrap_count + 8'sd1;
      end else if ((raw_level <= LO_LEVEL) && (raw_next >= HI_LEVEL)) begin
        if (wrap_count > WRAP_MIN) wrap_count_next = wrap_count - 8'sd1;
      end
      // wraps * 255 as wraps * 256 - wraps
      sig_full = $signed({9'd0, raw_next})
               + ($signed({wrap_count_next[BYTE_W-1], wrap_count_next, 8'd0}))
               - $signed({{9{wrap_count_next[BYTE_W-1]}}, wrap_count_next})
               - $signed({9'd0, zero_offset});
    end else begin
      sig_full = $signed({9'd0, raw_next});
    end
    sig_clamped = sig_full[16] ? '0 : sig_full[SIG_W-1:0];
  end

  // one deviation square per cycle
  always_comb begin
    acc_sel = held_accel[acc_idx];
    dev_abs = acc_sel[BYTE_W-1] ? (acc_sel - ACC_MID) : (ACC_MID - acc_sel);
    dev_sq  = SUM_W'(dev_abs) * SUM_W'(dev_abs);
  end

  // root step: two radicand bits per cycle
  always_comb begin
    root_shift = {root_rem, src_shift[SUM_W-1 -: 2]};
    root_trial = {2'b00, root, 2'b01};
    root_take  = (root_shift >= root_trial);
  end

  // divide step: one quotient bit per cycle
  always_comb begin
    div_shift = {div_rem, root[ROOT_W-1]};
    div_take  = (div_shift >= MAG_DIV);
  end

  // control, held state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      unwrap_enable  <= 1'b0;
      raw_level      <= '0;
      previous_level <= '0;
      wrap_count     <= '0;
      zero_offset    <= '0;
      initialised    <= 1'b0;
      held_accel[0]  <= '0;
      held_accel[1]  <= '0;
      held_accel[2]  <= '0;
      held_magnitude <= '0;
      held_falls     <= '0;
      out_valid      <= 1'b0;
      pend_valid     <= 1'b0;
      acc_idx        <= '0;
      step           <= '0;
    end else begin
      if (cfg_write) unwrap_enable <= cfg_data;

      // output word valid: load from the done state, clear once taken
      if ((state == S_DONE) && out_free) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            previous_level <= raw_level;
            raw_level      <= raw_next;
            wrap_count     <= wrap_count_next;
            pend_signal    <= sig_clamped;
            pend_valid     <= pkt_ok;
            if (!initialised) begin
              if (raw_next > OFFSET_MIN) zero_offset <= raw_next;
              initialised <= 1'b1;
            end
            if (pkt_ok) begin
              held_accel[0] <= in_acc_x;
              held_accel[1] <= in_acc_y;
              held_accel[2] <= in_acc_z;
              held_falls    <= (length_class == LEN_SIX) ? fall_byte : '0;
              sum_sq        <= '0;
              acc_idx       <= '0;
              state         <= S_SQUARE;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_SQUARE: begin
          if (acc_idx == 2'd2) begin
            src_shift <= sum_sq + dev_sq;
            root_rem  <= '0;
            root      <= '0;
            step      <= '0;
            state     <= S_ROOT;
          end else begin
            sum_sq <= sum_sq + dev_sq;
          end
          acc_idx <= acc_idx + 2'd1;
        end
        S_ROOT: begin
          src_shift <= {src_shift[SUM_W-3:0], 2'b00};
          if (root_take) begin
            root_rem <= REM_W'(root_shift - root_trial);
            root     <= {root[ROOT_W-2:0], 1'b1};
          end else begin
            root_rem <= root_shift[REM_W-1:0];
            root     <= {root[ROOT_W-2:0], 1'b0};
          end
          step <= step + STEP_W'(1);
          if (step == '1) begin
            div_rem <= '0;
            state   <= S_DIVIDE;
          end
        end
        S_DIVIDE: begin
          if (div_take) begin
            div_rem <= DREM_W'(div_shift - MAG_DIV);
            root    <= {root[ROOT_W-2:0], 1'b1};
          end else begin
            div_rem <= div_shift[DREM_W-1:0];
            root    <= {root[ROOT_W-2:0], 1'b0};
          end
          step <= step + STEP_W'(1);
          if (step == '1) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            unwrapped_signal <= pend_signal;
            out_acc_x        <= held_accel[0];
            out_acc_y        <= held_accel[1];
            out_acc_z        <= held_accel[2];
            fall_total       <= held_falls;
            packet_valid     <= pend_valid;
            if (pend_valid) begin
              held_magnitude  <= root[MAG_W-1:0];
              accel_magnitude <= root[MAG_W-1:0];
            end else begin
              accel_magnitude <= held_magnitude;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[sim/tb_top.sv]
// testbench for the sensor packet unwrap and acceleration magnitude block
`timescale 1ns / 1ps

module tb_top;
  import spua_pkg::*;

  localparam int CLK_HALF     = 5;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int LEVEL_SPAN   = 255;
  localparam int DRAIN_CYCLES = 60;
  localparam int HOLD_AFTER   = 150;
  localparam int HOLD_CYCLES  = 800;
  localparam logic [BYTE_W-1:0] HDR_OTHER = 8'hFD;
  localparam logic [LEN_W-1:0]  LEN_OTHER = 2'd2;
  localparam logic [LEN_W-1:0]  LEN_BAD   = 2'd3;

  typedef struct packed {
    logic [BYTE_W-1:0] hdr;
    logic [BYTE_W-1:0] ax;
    logic [BYTE_W-1:0] ay;
    logic [BYTE_W-1:0] az;
    logic [BYTE_W-1:0] pres;
    logic [BYTE_W-1:0] fall;
    logic [LEN_W-1:0]  lcls;
  } sensor_pkt_t;

  typedef struct packed {
    logic [SIG_W-1:0]  sig;
    logic [BYTE_W-1:0] ax;
    logic [BYTE_W-1:0] ay;
    logic [BYTE_W-1:0] az;
    logic [MAG_W-1:0]  mag;
    logic [BYTE_W-1:0] falls;
    logic              pv;
  } sensor_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic cfg_data = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic out_valid;
  logic out_ready = 1'b0;
  sensor_pkt_t cur_pkt = '0;
  logic [SIG_W-1:0]  unwrapped_signal;
  logic [BYTE_W-1:0] out_acc_x;
  logic [BYTE_W-1:0] out_acc_y;
  logic [BYTE_W-1:0] out_acc_z;
  logic [MAG_W-1:0]  accel_magnitude;
  logic [BYTE_W-1:0] fall_total;
  logic              packet_valid;

  // packets waiting for the driver, words waiting for the block
  sensor_pkt_t  pkt_queue[$];
  sensor_word_t expected_words[$];
  int err_count = 0;
  int words_seen = 0;
  int cycle_count = 0;

  // predictor copy of the block state
  logic              unwrap_on = 1'b0;
  logic [BYTE_W-1:0] raw_lvl = '0;
  logic [BYTE_W-1:0] prev_lvl = '0;
  int                wraps = 0;
  logic [BYTE_W-1:0] offset = '0;
  logic              init_done = 1'b0;
  logic [BYTE_W-1:0] held_acc[3] = '{default: '0};
  logic [MAG_W-1:0]  held_mag = '0;
  logic [BYTE_W-1:0] held_falls = '0;

  sensor_packet_unwrap_accel_magnitude dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .header_byte      (cur_pkt.hdr),
    .in_acc_x         (cur_pkt.ax),
    .in_acc_y         (cur_pkt.ay),
    .in_acc_z         (cur_pkt.az),
    .pressure_byte    (cur_pkt.pres),
    .fall_byte        (cur_pkt.fall),
    .length_class     (cur_pkt.lcls),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .unwrapped_signal (unwrapped_signal),
    .out_acc_x        (out_acc_x),
    .out_acc_y        (out_acc_y),
    .out_acc_z        (out_acc_z),
    .accel_magnitude  (accel_magnitude),
    .fall_total       (fall_total),
    .packet_valid     (packet_valid)
  );

  always #CLK_HALF clk = ~clk;

  // update the held state for one packet and queue the word it produces
  task automatic predict_packet(input sensor_pkt_t p);
    sensor_word_t w;
    logic [BYTE_W-1:0] axes[3];
    logic ok;
    int dev;
    int unsigned sq_sum;
    longint unsigned scaled;
    longint unsigned root;
    longint unsigned trial;
    int sig;
    int b;
    ok = (p.hdr == HDR_SUMMARY) && (p.lcls == LEN_SIX || p.lcls == LEN_FIVE);
    prev_lvl = raw_lvl;
    if (ok) begin
      raw_lvl = p.pres;
      axes = '{p.ax, p.ay, p.az};
      sq_sum = 0;
      for (b = 0; b < 3; b++) begin
        held_acc[b] = axes[b];
        dev = int'(axes[b]) - int'(ACC_MID);
        sq_sum += dev * dev;
      end
      // floor square root of sum << 16, one bit at a time from the top
      scaled = longint'(sq_sum) << 16;
      root = 0;
      for (b = 15; b >= 0; b--) begin
        trial = root | (64'd1 << b);
        if (trial * trial <= scaled) root = trial;
      end
      held_mag = MAG_W'(root / MAG_DIV);
      held_falls = (p.lcls == LEN_SIX) ? p.fall : '0;
    end
    // rollover tracking only once initialised and enabled
    if (init_done && unwrap_on) begin
      if (prev_lvl >= HI_LEVEL && raw_lvl <= LO_LEVEL) begin
        if (wraps < int'(WRAP_MAX)) wraps++;
      end else if (prev_lvl <= LO_LEVEL && raw_lvl >= HI_LEVEL) begin
        if (wraps > int'(WRAP_MIN)) wraps--;
      end
      sig = int'(raw_lvl) + wraps * LEVEL_SPAN - int'(offset);
    end else begin
      sig = int'(raw_lvl);
    end
    if (sig < 0) sig = 0;
    // first item sets the zero offset for high starting levels
    if (!init_done) begin
      if (raw_lvl > OFFSET_MIN) offset = raw_lvl;
      init_done = 1'b1;
    end
    w.sig   = SIG_W'(sig);
    w.ax    = held_acc[0];
    w.ay    = held_acc[1];
    w.az    = held_acc[2];
    w.mag   = held_mag;
    w.falls = held_falls;
    w.pv    = ok;
    expected_words.push_back(w);
  endtask

  function automatic sensor_pkt_t make_pkt(input logic [BYTE_W-1:0] hdr,
                                           input logic [BYTE_W-1:0] ax,
                                           input logic [BYTE_W-1:0] ay,
                                           input logic [BYTE_W-1:0] az,
                                           input logic [BYTE_W-1:0] pres,
                                           input logic [BYTE_W-1:0] fall,
                                           input logic [LEN_W-1:0] lcls);
    sensor_pkt_t p;
    p = '{hdr: hdr, ax: ax, ay: ay, az: az, pres: pres, fall: fall, lcls: lcls};
    return p;
  endfunction

  // accelerometer byte with extra weight on the extremes and zero point
  function automatic logic [BYTE_W-1:0] rand_acc();
    logic [BYTE_W-1:0] v;
    case ($urandom_range(0, 9))
      0: v = 8'h00;
      1: v = 8'hFF;
      2: v = ACC_MID;
      default: v = BYTE_W'($urandom_range(0, 255));
    endcase
    return v;
  endfunction

  // a packet the block must reject
  function automatic sensor_pkt_t junk_pkt();
    sensor_pkt_t p;
    p = make_pkt(BYTE_W'($urandom_range(0, 255)), rand_acc(), rand_acc(), rand_acc(),
                 BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)),
                 LEN_W'($urandom_range(0, 3)));
    if (p.hdr == HDR_SUMMARY) p.lcls = LEN_W'($urandom_range(LEN_OTHER, LEN_BAD));
    return p;
  endfunction

  // general mix of headers, length classes and pressure levels
  task automatic queue_mix(input int n);
    sensor_pkt_t p;
    int r;
    int i;
    for (i = 0; i < n; i++) begin
      p = make_pkt(HDR_SUMMARY, rand_acc(), rand_acc(), rand_acc(), '0,
                   BYTE_W'($urandom_range(0, 255)), LEN_SIX);
      if ($urandom_range(0, 4) == 0) p.hdr = BYTE_W'($urandom_range(0, 255));
      r = $urandom_range(0, 19);
      if (r < 9) p.lcls = LEN_SIX;
      else if (r < 17) p.lcls = LEN_FIVE;
      else if (r < 19) p.lcls = LEN_OTHER;
      else p.lcls = LEN_BAD;
      case ($urandom_range(0, 3))
        0: p.pres = BYTE_W'($urandom_range(0, 255));
        1: p.pres = BYTE_W'($urandom_range(0, 35));
        2: p.pres = BYTE_W'($urandom_range(220, 255));
        default: p.pres = BYTE_W'($urandom_range(100, 160));
      endcase
      pkt_queue.push_back(p);
    end
  endtask

  // runs of rollovers in one direction with rejected packets mixed in;
  // a mid level between wraps keeps the return leg from counting back
  task automatic queue_wrap_run(input int n, input bit forward);
    logic [BYTE_W-1:0] hi;
    logic [BYTE_W-1:0] lo;
    logic [BYTE_W-1:0] mid;
    logic [LEN_W-1:0] lc;
    int i;
    for (i = 0; i < n; i++) begin
      hi  = BYTE_W'($urandom_range(HI_LEVEL, 255));
      lo  = BYTE_W'($urandom_range(0, LO_LEVEL));
      mid = BYTE_W'($urandom_range(LO_LEVEL + 1, HI_LEVEL - 1));
      lc  = $urandom_range(0, 1) ? LEN_SIX : LEN_FIVE;
      pkt_queue.push_back(make_pkt(HDR_SUMMARY, rand_acc(), rand_acc(), rand_acc(),
                                   mid, BYTE_W'($urandom_range(0, 255)), lc));
      pkt_queue.push_back(make_pkt(HDR_SUMMARY, rand_acc(), rand_acc(), rand_acc(),
                                   forward ? hi : lo, BYTE_W'($urandom_range(0, 255)), lc));
      if ($urandom_range(0, 11) == 0) pkt_queue.push_back(junk_pkt());
      pkt_queue.push_back(make_pkt(HDR_SUMMARY, rand_acc(), rand_acc(), rand_acc(),
                                   forward ? lo : hi, BYTE_W'($urandom_range(0, 255)), lc));
    end
  endtask

  // wait until every packet went in and every word came out
  task automatic wait_drained();
    while (pkt_queue.size() != 0 || in_valid || expected_words.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_unwrap(input logic v);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= v;
    unwrap_on = v;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // sender: bursts of words with random gaps
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (in_valid && in_ready) predict_packet(cur_pkt);
      if (in_valid && !in_ready) begin
        // hold the current word until taken
      end else if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left--;
      end else if (pkt_queue.size() > 0) begin
        cur_pkt  <= pkt_queue.pop_front();
        in_valid <= 1'b1;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 20);
          case ($urandom_range(0, 3))
            0: gap_left = 0;
            1: gap_left = $urandom_range(1, 5);
            2: gap_left = $urandom_range(10, 60);
            default: gap_left = 0;
          endcase
        end else begin
          burst_left--;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: own stall pattern, one long hold-off, and the word check
  int ready_left = 0;
  logic ready_level = 1'b0;
  int hold_left = 0;
  bit held_off = 1'b0;
  sensor_word_t got_word;
  sensor_word_t exp_word;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got_word = '{sig: unwrapped_signal, ax: out_acc_x, ay: out_acc_y, az: out_acc_z,
                     mag: accel_magnitude, falls: fall_total, pv: packet_valid};
        words_seen++;
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word sig=%0d acc=%0d,%0d,%0d mag=%0d falls=%0d valid=%0b",
                   $time, got_word.sig, got_word.ax, got_word.ay, got_word.az,
                   got_word.mag, got_word.falls, got_word.pv);
          err_count++;
        end else begin
          exp_word = expected_words.pop_front();
          if (got_word !== exp_word) begin
            $display("%0t: mismatch expected sig=%0d acc=%0d,%0d,%0d mag=%0d falls=%0d valid=%0b",
                     $time, exp_word.sig, exp_word.ax, exp_word.ay, exp_word.az,
                     exp_word.mag, exp_word.falls, exp_word.pv);
            $display("%0t:          actual   sig=%0d acc=%0d,%0d,%0d mag=%0d falls=%0d valid=%0b",
                     $time, got_word.sig, got_word.ax, got_word.ay, got_word.az,
                     got_word.mag, got_word.falls, got_word.pv);
            err_count++;
          end
        end
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (!held_off && words_seen >= HOLD_AFTER) begin
        held_off = 1'b1;
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        if (ready_left == 0) begin
          case ($urandom_range(0, 7))
            0, 1: begin ready_level = 1'b0; ready_left = $urandom_range(1, 8); end
            6:    begin ready_level = 1'b1; ready_left = $urandom_range(100, 300); end
            7:    begin ready_level = 1'b0; ready_left = $urandom_range(20, 80); end
            default: begin ready_level = 1'b1; ready_left = $urandom_range(1, 30); end
          endcase
        end
        out_ready <= ready_level;
        ready_left--;
      end
    end
  end

  // run limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // reset, then phases of stimulus with register writes between them
  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    write_unwrap(1'b1);

    // directed: init with a high level, wrap boundaries, clamping, rejects
    pkt_queue.push_back(make_pkt(HDR_SUMMARY, 8'd128, 8'd128, 8'd128, 8'd200, 8'h00, LEN_SIX));
    pkt_queue.push_back(make_pkt(HDR_SUMMARY, 8'd0, 8'd0, 8'd0, 8'd240, 8'hFF, LEN_SIX));
    pkt_queue.push_back(make_pkt(HDR_SUMMARY, 8'd255, 8'd255, 8'd255, 8'd10, 8'hAA, LEN_FIVE));
    pkt_queue.push_back(make_pkt(HDR_SUMMARY, 8'd0, 8'd255, 8'd128, 8'd250, 8'h55, LEN_SIX));
    pkt_queue.push_back(make_pkt(HDR_SUMMARY, 8'd1, 8'd2, 8'd3, LO_LEVEL, 8'h0F, LEN_SIX));
    pkt_queue.push_back(make_pkt(HDR_SUMMARY, 8'd254, 8'd127, 8'd129, HI_LEVEL, 8'hF0, LEN_SIX));
    pkt_queue.push_back(make_pkt(HDR_SUMMARY, 8'd64, 8'd192, 8'd128, 8'd26, 8'h01, LEN_FIVE));
    pkt_queue.push_back(make_pkt(HDR_SUMMARY, 8'd128, 8'd0, 8'd255, 8'd229, 8'h80, LEN_SIX));
    pkt_queue.push_back(make_pkt(HDR_SUMMARY, 8'd200, 8'd50, 8'd90, 8'd0, 8'h7F, LEN_SIX));
    pkt_queue.push_back(make_pkt(HDR_SUMMARY, 8'd10, 8'd20, 8'd30, 8'd255, 8'hFE, LEN_SIX));
    pkt_queue.push_back(make_pkt(8'h00, 8'd0, 8'd0, 8'd0, 8'd77, 8'h00, LEN_SIX));
    pkt_queue.push_back(make_pkt(8'hFF, 8'd255, 8'd255, 8'd255, 8'd5, 8'hFF, LEN_FIVE));
    pkt_queue.push_back(make_pkt(HDR_OTHER, 8'd1, 8'd1, 8'd1, 8'd240, 8'h11, LEN_SIX));
    pkt_queue.push_back(make_pkt(HDR_SUMMARY, 8'd9, 8'd9, 8'd9, 8'd3, 8'h22, LEN_OTHER));
    pkt_queue.push_back(make_pkt(HDR_SUMMARY, 8'd7, 8'd7, 8'd7, 8'd4, 8'h33, LEN_BAD));
    pkt_queue.push_back(make_pkt(8'h01, 8'd128, 8'd128, 8'd128, 8'd100, 8'h44, LEN_OTHER));
    pkt_queue.push_back(make_pkt(HDR_SUMMARY, 8'd255, 8'd0, 8'd255, 8'd127, 8'hFF, LEN_SIX));
    pkt_queue.push_back(make_pkt(HDR_SUMMARY, 8'd0, 8'd255, 8'd0, 8'd128, 8'hFF, LEN_SIX));
    pkt_queue.push_back(make_pkt(HDR_SUMMARY, 8'd128, 8'd128, 8'd129, 8'd0, 8'hFF, LEN_FIVE));
    pkt_queue.push_back(make_pkt(HDR_SUMMARY, 8'd127, 8'd128, 8'd128, 8'd255, 8'h00, LEN_SIX));
    wait_drained();

    queue_mix(60);
    wait_drained();

    // unwrapping off: plain raw level, no rollover counting
    write_unwrap(1'b0);
    queue_mix(30);
    wait_drained();

    // unwrapping on: drive the wrap count into both saturation limits
    write_unwrap(1'b1);
    queue_wrap_run(160, 1'b1);
    wait_drained();
    queue_wrap_run(270, 1'b0);
    wait_drained();

    write_unwrap(1'b0);
    queue_mix(10);
    wait_drained();

    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
